// File: rtl/fir_filter_64tap_macros.svh
// Assertion macros used by the checker file of the FIR filter.
// Holds nothing but macro definitions; no other file is needed.
`ifndef FIR_FILTER_64TAP_MACROS_SVH
`define FIR_FILTER_64TAP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fir_pkg.sv
// Shared constants, types and the sequencer state encoding for the FIR filter.
// No dependencies.
package fir_pkg;

  localparam int TAPS        = 64;
  localparam int LINE_DEPTH  = 64;
  localparam int LINE_AW     = 6;
  localparam int COEF_WORDS  = 8;
  localparam int COEF_IW     = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int SAMPLE_W    = 8;
  localparam int COEF_W      = 8;
  localparam int PROD_W      = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W       = 24;
  localparam int OUT_SHIFT   = 7;
  localparam int OUT_OFFSET  = 128;
  localparam int DAC_W       = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } fir_state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic tap_v;
    logic tap_last;
  } mac_ctrl_t;

endpackage

// File: rtl/fir_filter_64tap.sv
// Top level of the 64-tap direct-form FIR filter: sequencer, output register.
// Depends on fir_pkg, fir_line_mem, fir_coef_bank and fir_mac.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall   in_sample
//   out       output     out_valid/out_stall out_dac_value, out_clipped
//   cfg       input      cfg_we              cfg_index, cfg_wdata
//
// Each word takes one delay-line RAM read per tap over a single multiplier,
// then the multiply, accumulate and output registers. A new word is accepted
// once the previous one has reached the output register, even while that
// result is stalled. Reset is synchronous; the delay line reads as zero until
// written, through per-entry valid bits.
module fir_filter_64tap
  import fir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DAC_W-1:0]      out_dac_value,
  output logic                  out_clipped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  fir_state_t          state_r, state_nxt;
  logic [LINE_AW-1:0]  cnt_r, cnt_nxt;
  logic [LINE_AW-1:0]  newest_r, newest_nxt;
  logic                tap_v_r;
  logic                tap_last_r;
  logic                out_valid_r;
  logic [DAC_W-1:0]    out_dac_r;
  logic                out_clip_r;

  logic                issue;
  logic                issue_last;
  logic                mac_clr;
  logic                load_out;
  logic                out_free;
  logic                line_we;
  logic [LINE_AW-1:0]  raddr;
  logic [SAMPLE_W-1:0] tap_sample;
  logic [COEF_W-1:0]   tap_coef;
  mac_ctrl_t           mac_ctrl;
  logic                acc_rdy;
  logic [DAC_W-1:0]    mac_dac;
  logic                mac_clip;

  assign out_free = !out_valid_r || !out_stall;
  assign line_we  = (state_r == ST_IDLE) && in_valid;
  assign raddr    = newest_r + cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      newest_r   <= '0;
      tap_v_r    <= 1'b0;
      tap_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      newest_r   <= newest_nxt;
      tap_v_r    <= issue;
      tap_last_r <= issue_last;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    newest_nxt = newest_r;
    issue      = 1'b0;
    issue_last = 1'b0;
    mac_clr    = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mac_clr   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue      = 1'b1;
        issue_last = (cnt_r == LINE_AW'(TAPS - 1));
        cnt_nxt    = cnt_r + 1'b1;
        if (issue_last) begin
          // The newest slot moves down once all taps have been read.
          newest_nxt = newest_r - 1'b1;
          state_nxt  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_rdy) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  assign mac_ctrl.clr      = mac_clr;
  assign mac_ctrl.tap_v    = tap_v_r;
  assign mac_ctrl.tap_last = tap_last_r;

  fir_line_mem u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (line_we),
    .waddr (newest_r),
    .wdata (in_sample),
    .ren   (issue),
    .raddr (raddr),
    .rdata (tap_sample)
  );

  fir_coef_bank u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tap_ren   (issue),
    .tap_idx   (cnt_r),
    .coef      (tap_coef)
  );

  fir_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .sample    (tap_sample),
    .coef      (tap_coef),
    .acc_rdy   (acc_rdy),
    .dac_value (mac_dac),
    .clipped   (mac_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dac_r  <= mac_dac;
      out_clip_r <= mac_clip;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dac_value = out_dac_r;
  assign out_clipped   = out_clip_r;

endmodule

// File: rtl/fir_line_mem.sv
// Circular delay line: a 64 x 8 synchronous RAM with a registered read.
// Depends on fir_pkg. Entries never written since reset read as zero.
module fir_line_mem
  import fir_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [LINE_AW-1:0]  waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                ren,
  input  logic [LINE_AW-1:0]  raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0]   mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] vld_r;
  logic [SAMPLE_W-1:0]   rdata_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  // One valid bit per entry stands in for clearing the RAM at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (ren) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// File: rtl/fir_coef_bank.sv
// Coefficient registers written over the configuration port, with a
// registered tap select. Depends on fir_pkg.
module fir_coef_bank
  import fir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  tap_ren,
  input  logic [LINE_AW-1:0]    tap_idx,
  output logic [COEF_W-1:0]     coef
);

  logic [CFG_DATA_W-1:0] coef_r [COEF_WORDS];
  logic [COEF_W-1:0]     coef_q_r;
  logic [CFG_DATA_W-1:0] word_sel;
  logic [2:0]            byte_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_WORDS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(COEF_WORDS))) begin
      coef_r[cfg_index[COEF_IW-1:0]] <= cfg_wdata;
    end
  end

  assign word_sel = coef_r[tap_idx[LINE_AW-1:3]];
  assign byte_sel = tap_idx[2:0];

  always_ff @(posedge clk) begin
    if (tap_ren) begin
      coef_q_r <= word_sel[{byte_sel, 3'b000} +: COEF_W];
    end
  end

  assign coef = coef_q_r;

endmodule

// File: rtl/fir_mac.sv
// Multiply-accumulate unit with the output scaling and saturation.
// Depends on fir_pkg.
module fir_mac
  import fir_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mac_ctrl_t           ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [COEF_W-1:0]   coef,
  output logic                acc_rdy,
  output logic [DAC_W-1:0]    dac_value,
  output logic                clipped
);

  localparam int SH_W = ACC_W - OUT_SHIFT;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic                     prod_last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     acc_rdy_r;
  logic signed [SH_W-1:0]   shifted;
  logic signed [SH_W:0]     biased;

  always_ff @(posedge clk) begin
    if (ctrl.tap_v) begin
      prod_r <= $signed({1'b0, sample}) * $signed(coef);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      acc_rdy_r   <= 1'b0;
      acc_r       <= '0;
    end else if (ctrl.clr) begin
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      acc_rdy_r   <= 1'b0;
      acc_r       <= '0;
    end else begin
      prod_v_r    <= ctrl.tap_v;
      prod_last_r <= ctrl.tap_v && ctrl.tap_last;
      acc_rdy_r   <= prod_v_r && prod_last_r;
      if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // The arithmetic shift by seven is the fixed-point form of the 1/128 scale.
  assign shifted = acc_r[ACC_W-1:OUT_SHIFT];
  assign biased  = {shifted[SH_W-1], shifted} + (SH_W+1)'(OUT_OFFSET);

  always_comb begin
    if (biased < 0) begin
      dac_value = '0;
      clipped   = 1'b1;
    end else if (biased > (SH_W+1)'((1 << DAC_W) - 1)) begin
      dac_value = '1;
      clipped   = 1'b1;
    end else begin
      dac_value = biased[DAC_W-1:0];
      clipped   = 1'b0;
    end
  end

  assign acc_rdy = acc_rdy_r;

endmodule

// File: rtl/fir_filter_64tap_chk.sv
// Port-level checker for the FIR filter, bound to the top level.
// Depends on fir_pkg and fir_filter_64tap_macros.svh.
`include "fir_filter_64tap_macros.svh"

module fir_filter_64tap_chk
  import fir_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [DAC_W-1:0] out_dac_value,
  input logic             out_clipped
);

  logic           in_take;
  logic           out_wait;
  logic [DAC_W:0] out_word;
  logic           at_rail;

  assign in_take  = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;
  assign out_word = {out_dac_value, out_clipped};
  assign at_rail  = (out_dac_value == '0) || (out_dac_value == '1);

  // A result that waits must stay offered.
  `FIR_ASSERT_NEXT(a_out_hold, out_wait, out_valid, "result word dropped while stalled")

  // A result that waits must not change.
  `FIR_ASSERT_NEXT(a_out_stable, out_wait, $stable(out_word), "stalled result word changed")

  // A clipped result sits at one of the two rails.
  `FIR_ASSERT_NOW(a_clip_rail, out_valid && out_clipped, at_rail, "clipped word not at a rail")

  // Having taken a word, the filter is busy; this checks the start of the tap sweep.
  `FIR_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "input taken again too soon")

  // Leaving reset, the input side is free.
  `FIR_ASSERT_NOW(a_idle_after_reset, $rose(rst_n), !in_stall, "input stalled after reset")

endmodule

bind fir_filter_64tap fir_filter_64tap_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_dac_value (out_dac_value),
  .out_clipped   (out_clipped)
);

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fir_filter_64tap: random and directed sample words, several
// coefficient sets, and a built-in predictor of the filter output and clip flag.
// Depends on fir_pkg and the fir_filter_64tap RTL only.
module tb;
  import fir_pkg::*;

  localparam int DAC_MAX         = (1 << DAC_W) - 1;
  localparam int DRAIN_GAP       = TAPS + 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_LEN        = 400;
  localparam int PHASE_WORDS     = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef enum int {
    CK_ZERO,
    CK_IMPULSE_POS,
    CK_IMPULSE_NEG,
    CK_FULL_POS,
    CK_FULL_NEG,
    CK_BANDPASS,
    CK_SMALL,
    CK_LAST_TAP,
    CK_RANDOM
  } coef_kind_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_value;
    logic             clipped;
  } dac_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DAC_W-1:0]      out_dac_value;
  logic                  out_clipped;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Words waiting to be offered, and filter outputs still to arrive.
  logic [SAMPLE_W-1:0] adc_words [$];
  dac_result_t         dac_expect [$];

  // Predictor state: coefficient bank, delay line and newest slot.
  logic [CFG_DATA_W-1:0] coef_q [COEF_WORDS];
  logic [SAMPLE_W-1:0]   line_q [LINE_DEPTH];
  logic [LINE_AW-1:0]    newest_q = '0;

  logic        in_fire = 1'b0;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 22;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  int          words_in = 0;
  int          results_out = 0;
  int          clipped_seen = 0;
  int          coef_loads = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          r;
  dac_result_t want;

  fir_filter_64tap uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_value (out_dac_value),
    .out_clipped   (out_clipped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stores the new word, forms the 64-tap sum and queues the saturated output.
  function automatic void fir_predict(input logic [SAMPLE_W-1:0] s);
    int                 acc;
    int                 cv;
    int                 k;
    int                 level;
    logic [LINE_AW-1:0] slot;
    logic [COEF_W-1:0]  cb;
    dac_result_t        res;
    line_q[newest_q] = s;
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      slot = newest_q + LINE_AW'(k);
      cb = coef_q[k / 8][COEF_W * (k % 8) +: COEF_W];
      cv = $signed(cb);
      acc += cv * int'(line_q[slot]);
    end
    level = (acc >>> OUT_SHIFT) + OUT_OFFSET;
    res.clipped = (level < 0) || (level > DAC_MAX);
    if (level < 0) begin
      level = 0;
    end else if (level > DAC_MAX) begin
      level = DAC_MAX;
    end
    res.dac_value = DAC_W'(level);
    if (res.clipped) clipped_seen++;
    dac_expect.push_back(res);
    newest_q = newest_q - 1'b1;
  endfunction

  // Mostly uniform, with words at the rails and words near mid-scale.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return SAMPLE_W'($urandom_range(255));
    if (pick < 75) return $urandom_range(1) ? 8'd255 : 8'd0;
    return SAMPLE_W'(120 + $urandom_range(16));
  endfunction

  // Sender: a new word is offered only once the current one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else if (!in_valid || in_fire) begin
      if (adc_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= adc_words[0];
      end else begin
        in_valid  <= 1'b0;
        in_sample <= SAMPLE_W'($urandom);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the filter back up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (!hold_done && results_out >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: follows register writes, predicts each accepted word, checks results.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
      for (r = 0; r < COEF_WORDS; r++) coef_q[r] = '0;
      for (r = 0; r < LINE_DEPTH; r++) line_q[r] = '0;
      newest_q = '0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_out++;
        if (dac_expect.size() == 0) begin
          $error("unexpected result: dac_value %0d clipped %0b", out_dac_value, out_clipped);
          mismatches++;
        end else begin
          want = dac_expect.pop_front();
          if (out_dac_value !== want.dac_value) begin
            $error("dac_value: expected %0d, got %0d", want.dac_value, out_dac_value);
            mismatches++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_clipped);
            mismatches++;
          end
        end
      end
      if (cfg_we && cfg_index < COEF_WORDS) coef_q[cfg_index[COEF_IW-1:0]] = cfg_wdata;
      if (in_valid && !in_stall) begin
        fir_predict(in_sample);
        void'(adc_words.pop_front());
        words_in++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Writes all eight coefficient words, then one index beyond the bank.
  task automatic load_coefs(input coef_kind_t kind);
    logic [CFG_DATA_W-1:0] word;
    int                    w;
    int                    b;
    for (w = 0; w < COEF_WORDS; w++) begin
      case (kind)
        CK_ZERO:        word = '0;
        CK_IMPULSE_POS: word = (w == 0) ? 64'h7F : '0;
        CK_IMPULSE_NEG: word = (w == 0) ? 64'h80 : '0;
        CK_FULL_POS:    word = {8{8'h7F}};
        CK_FULL_NEG:    word = {8{8'h80}};
        CK_BANDPASS: begin
          // Symmetric band-pass set: tap 63-k equals tap k.
          case (w)
            0:       word = 64'hFE02_0301_FFFE_FF00;
            1:       word = 64'hE2F0_0610_0B00_F8F9;
            2:       word = 64'hDCB0_C400_302E_08EA;
            3:       word = 64'h30EE_B8C8_0A50_5E2A;
            4:       word = 64'h2A5E_500A_C8B8_EE30;
            5:       word = 64'hEA08_2E30_00C4_B0DC;
            6:       word = 64'hF9F8_000B_1006_F0E2;
            default: word = 64'h00FF_FEFF_0103_02FE;
          endcase
        end
        CK_SMALL: begin
          for (b = 0; b < 8; b++) begin
            word[COEF_W * b +: COEF_W] = COEF_W'($urandom_range(15)) - 8'd8;
          end
        end
        CK_LAST_TAP: begin
          // Only the oldest tap is live, so the full line depth must be used.
          word = (w == COEF_WORDS - 1) ? {COEF_W'($urandom_range(1, 255)), 56'h0} : '0;
        end
        default:        word = {$urandom, $urandom};
      endcase
      write_cfg(CFG_IDX_W'(w), word);
    end
    write_cfg(CFG_IDX_W'(COEF_WORDS + $urandom_range(COEF_WORDS - 1)), {$urandom, $urandom});
    coef_loads++;
  endtask

  task automatic wait_drained();
    while (adc_words.size() != 0 || dac_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic random_phase(input coef_kind_t kind, input int idle_pct);
    int i;
    load_coefs(kind);
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    for (i = 0; i < PHASE_WORDS; i++) adc_words.push_back(next_sample());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients at their reset value: every word must give mid-scale.
    adc_words.push_back(8'd255);
    adc_words.push_back(8'd0);
    wait_drained();

    // A write outside the bank must leave the coefficients alone.
    write_cfg(CFG_IDX_TOP, '1);
    load_coefs(CK_IMPULSE_POS);
    @(posedge clk);
    adc_words.push_back(8'd255);
    adc_words.push_back(8'd0);
    adc_words.push_back(8'd1);
    adc_words.push_back(8'd128);
    adc_words.push_back(8'h55);
    adc_words.push_back(8'hAA);
    wait_drained();

    // Most negative single tap: 128 lands exactly on zero, 129 clips low.
    load_coefs(CK_IMPULSE_NEG);
    @(posedge clk);
    adc_words.push_back(8'd255);
    adc_words.push_back(8'd128);
    adc_words.push_back(8'd129);
    adc_words.push_back(8'd127);
    wait_drained();

    // All taps at the largest positive coefficient, then at the most negative one.
    load_coefs(CK_FULL_POS);
    @(posedge clk);
    repeat (3) adc_words.push_back(8'd255);
    wait_drained();
    load_coefs(CK_FULL_NEG);
    @(posedge clk);
    repeat (3) adc_words.push_back(8'd255);
    wait_drained();

    random_phase(CK_BANDPASS, 22);
    random_phase(CK_RANDOM, 22);
    random_phase(CK_SMALL, 0);
    random_phase(CK_LAST_TAP, 22);
    random_phase(CK_RANDOM, 22);
    random_phase(CK_BANDPASS, 22);

    $display("Run covered %0d sample words and %0d filter outputs (%0d clipped).",
             words_in, results_out, clipped_seen);
    $display("Coefficient sets loaded: %0d.", coef_loads);
    if (dac_expect.size() != 0) begin
      $error("%0d filter outputs never arrived", dac_expect.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: fir_filter_64tap.f
+incdir+rtl
rtl/fir_pkg.sv
rtl/fir_line_mem.sv
rtl/fir_coef_bank.sv
rtl/fir_mac.sv
rtl/fir_filter_64tap.sv
rtl/fir_filter_64tap_chk.sv
test/tb.sv
